FILE: rtl/core/adac_pkg.sv
// ----------------------------------------------------------------------------
// adac_pkg
// Shared types and constants for the array descriptor address check core:
// field widths, codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package adac_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_DIMS_DEF   = 8;
	localparam int INDEX_BITS_DEF = 32;
	localparam int ADDR_BITS_DEF  = 48;

	// Fixed field widths
	localparam int FIELD_IDX_W  = 32;
	localparam int FIELD_ADDR_W = 48;
	localparam int DIM_W        = 3;
	localparam int ESIZE_W      = 16;
	localparam int DCOUNT_W     = 4;
	localparam int STATUS_W     = 2;
	localparam int CFG_DATA_W   = 48;
	localparam int CFG_IDX_W    = 2;
	// dimension counts up to 15 plus headroom for the increment
	localparam int CNT_W        = DCOUNT_W + 1;

	// Shared multiplier: 32 x 32 partial products, 64-bit product
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ELEM_BYTES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

	// Input op codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SUB  = 1'b1;

	// Result kinds
	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_ADDR = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_WIDTH = 2'd2;

	// Operand pair for the shared multiplier
	typedef enum logic [2:0] {
		MUL_AL_BL,   // acc low  x width low
		MUL_AL_BH,   // acc low  x width high
		MUL_AH_BL,   // acc high x width low
		MUL_AL_ES,   // acc low  x element size
		MUL_AH_ES    // acc high x element size
	} adac_mul_sel_t;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_M0,
		S_M1,
		S_M2,
		S_STEP,
		S_E0,
		S_E1,
		S_E2,
		S_EMIT
	} adac_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic          load_bounds;  // write bound tables, build ack result
		logic          sub_capture;  // register incoming subscript
		logic          check;        // bounds check, width and difference
		adac_mul_sel_t mul_sel;
		logic          add_en;       // add last product into the running sum
		logic          add_shift;    // that product sits 32 bits up
		logic          acc_commit;   // running sum becomes the offset
		logic          dim_advance;
		logic          sum_base;     // preload running sum with base address
		logic          res_addr;     // address result from running sum
		logic          res_fault;    // range fault result
		logic          out_load;     // result into output register
		logic          seq_clear;    // drop the subscript sequence
	} adac_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic last;   // current subscript completes the sequence
		logic fault;  // a subscript of this sequence failed its check
	} adac_sts_t;

endpackage

FILE: rtl/core/adac_ctrl.sv
// ----------------------------------------------------------------------------
// adac_ctrl
// Sequencer: input handshake, multiply schedule, output register valid.
// ----------------------------------------------------------------------------
module adac_ctrl
	import adac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      op,
	output logic      out_valid,
	input  logic      out_stall,
	input  adac_sts_t sts,
	output adac_cmd_t cmd
);

	adac_state_t state_q, state_d;
	logic        out_valid_q;
	logic        accept;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mul_sel = MUL_AL_BL;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == OP_LOAD) begin
						cmd.load_bounds = 1'b1;
						cmd.seq_clear   = 1'b1;
						state_d         = S_EMIT;
					end else begin
						cmd.sub_capture = 1'b1;
						state_d         = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_M0;
			end
			S_M0: begin
				cmd.mul_sel = MUL_AL_BL;
				state_d     = S_M1;
			end
			S_M1: begin
				cmd.mul_sel = MUL_AL_BH;
				cmd.add_en  = 1'b1;
				state_d     = S_M2;
			end
			S_M2: begin
				cmd.mul_sel   = MUL_AH_BL;
				cmd.add_en    = 1'b1;
				cmd.add_shift = 1'b1;
				state_d       = S_STEP;
			end
			S_STEP: begin
				cmd.add_en     = 1'b1;
				cmd.add_shift  = 1'b1;
				cmd.acc_commit = 1'b1;
				if (!sts.last) begin
					cmd.dim_advance = 1'b1;
					state_d         = S_IDLE;
				end else if (sts.fault) begin
					cmd.res_fault = 1'b1;
					state_d       = S_EMIT;
				end else begin
					cmd.sum_base = 1'b1;
					state_d      = S_E0;
				end
			end
			S_E0: begin
				cmd.mul_sel = MUL_AL_ES;
				state_d     = S_E1;
			end
			S_E1: begin
				cmd.mul_sel = MUL_AH_ES;
				cmd.add_en  = 1'b1;
				state_d     = S_E2;
			end
			S_E2: begin
				cmd.add_en    = 1'b1;
				cmd.add_shift = 1'b1;
				cmd.res_addr  = 1'b1;
				state_d       = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load  = 1'b1;
					cmd.seq_clear = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/adac_datapath.sv
// ----------------------------------------------------------------------------
// adac_datapath
// Bound tables, configuration registers, bounds check, shared 32x32
// multiplier with running sum, and the output register.
// ----------------------------------------------------------------------------
module adac_datapath
	import adac_pkg::*;
#(
	parameter int MAX_DIMS   = MAX_DIMS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic [DIM_W-1:0]        dim,
	input  logic [FIELD_IDX_W-1:0]  lower,
	input  logic [FIELD_IDX_W-1:0]  upper,
	input  logic [FIELD_IDX_W-1:0]  subscript,
	output logic                    kind,
	output logic [STATUS_W-1:0]     status,
	output logic [DIM_W-1:0]        bad_dim,
	output logic [FIELD_ADDR_W-1:0] address,
	input  adac_cmd_t               cmd,
	output adac_sts_t               sts
);

	localparam int TIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int IW2    = INDEX_BITS + 2;
	localparam logic signed [IW2-1:0] ONE = IW2'(1);

	// dimension index folded onto the table depth
	function automatic logic [TIDX_W-1:0] dim_fold(input logic [DIM_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = CNT_W'(v);
		for (int i = 0; i < (1 << DIM_W); i++) begin
			if (r >= CNT_W'(MAX_DIMS)) begin
				r = r - CNT_W'(MAX_DIMS);
			end
		end
		return TIDX_W'(r);
	endfunction

	// configuration
	logic [ESIZE_W-1:0]    esize_q;
	logic [DCOUNT_W-1:0]   dcount_q;
	logic [CFG_DATA_W-1:0] base_q;

	// sequence state
	logic [ADDR_BITS-1:0]  offset_acc_q;
	logic [TIDX_W-1:0]     next_dim_q;
	logic                  range_fault_q;
	logic [TIDX_W-1:0]     fault_dim_q;

	// bound tables
	logic [INDEX_BITS-1:0] lower_mem [MAX_DIMS];
	logic [INDEX_BITS-1:0] upper_mem [MAX_DIMS];

	// working registers
	logic [INDEX_BITS-1:0] sub_s1;
	logic [INDEX_BITS-1:0] lo_s1, hi_s1;   // bounds of the current dimension
	logic [ADDR_BITS-1:0]  width_q;
	logic [ADDR_BITS-1:0]  sum_q;
	logic [PROD_W-1:0]     mult_s1;

	// result waiting for the output register
	logic                  res_kind_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [DIM_W-1:0]      res_bad_q;
	logic [ADDR_BITS-1:0]  res_addr_q;

	// output register
	logic                    kind_q;
	logic [STATUS_W-1:0]     status_q;
	logic [DIM_W-1:0]        bad_dim_q;
	logic [FIELD_ADDR_W-1:0] address_q;

	// bounds load
	logic [TIDX_W-1:0]     ld_idx;
	logic signed [IW2-1:0] ld_lo_x, ld_hi_x, ld_width;

	assign ld_idx   = dim_fold(dim);
	assign ld_lo_x  = {{2{lower[INDEX_BITS-1]}}, lower[INDEX_BITS-1:0]};
	assign ld_hi_x  = {{2{upper[INDEX_BITS-1]}}, upper[INDEX_BITS-1:0]};
	assign ld_width = ld_hi_x - ld_lo_x + ONE;

	// subscript check against the current dimension
	logic signed [IW2-1:0] lo_x, hi_x, sub_x, width_x, diff_x;
	logic                  out_of_range;

	assign lo_x         = {{2{lo_s1[INDEX_BITS-1]}}, lo_s1};
	assign hi_x         = {{2{hi_s1[INDEX_BITS-1]}}, hi_s1};
	assign sub_x        = {{2{sub_s1[INDEX_BITS-1]}}, sub_s1};
	assign width_x      = hi_x - lo_x + ONE;
	assign diff_x       = sub_x - lo_x;
	assign out_of_range = (sub_x < lo_x) || (sub_x > hi_x);

	// sequence end: clamp dimension count to 1..MAX_DIMS
	logic [CNT_W-1:0] dc_ext, n_used, nd_inc;

	assign dc_ext = CNT_W'(dcount_q);
	assign n_used = (dc_ext == '0) ? CNT_W'(1) :
			(dc_ext > CNT_W'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) : dc_ext;
	assign nd_inc = CNT_W'(next_dim_q) + CNT_W'(1);

	assign sts.last  = (nd_inc >= n_used);
	assign sts.fault = range_fault_q;

	// shared multiplier operands, modulo 2^ADDR_BITS split in 32-bit halves
	logic [PROD_W-1:0]    acc_ext, wid_ext;
	logic [MUL_W-1:0]     mul_a, mul_b;
	logic [PROD_W-1:0]    term_full;
	logic [ADDR_BITS-1:0] sum_next;

	assign acc_ext = PROD_W'(offset_acc_q);
	assign wid_ext = PROD_W'(width_q);

	always_comb begin
		case (cmd.mul_sel)
			MUL_AL_BL: begin
				mul_a = acc_ext[MUL_W-1:0];
				mul_b = wid_ext[MUL_W-1:0];
			end
			MUL_AL_BH: begin
				mul_a = acc_ext[MUL_W-1:0];
				mul_b = wid_ext[PROD_W-1:MUL_W];
			end
			MUL_AH_BL: begin
				mul_a = acc_ext[PROD_W-1:MUL_W];
				mul_b = wid_ext[MUL_W-1:0];
			end
			MUL_AL_ES: begin
				mul_a = acc_ext[MUL_W-1:0];
				mul_b = MUL_W'(esize_q);
			end
			MUL_AH_ES: begin
				mul_a = acc_ext[PROD_W-1:MUL_W];
				mul_b = MUL_W'(esize_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign term_full = cmd.add_shift ? {mult_s1[MUL_W-1:0], {MUL_W{1'b0}}} : mult_s1;
	assign sum_next  = cmd.add_en ? (sum_q + term_full[ADDR_BITS-1:0]) : sum_q;

	// control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esize_q       <= ESIZE_W'(1);
			dcount_q      <= DCOUNT_W'(1);
			base_q        <= '0;
			offset_acc_q  <= '0;
			next_dim_q    <= '0;
			range_fault_q <= 1'b0;
			fault_dim_q   <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ELEM_BYTES:   esize_q  <= cfg_data[ESIZE_W-1:0];
					REG_DIM_COUNT:    dcount_q <= cfg_data[DCOUNT_W-1:0];
					REG_BASE_ADDRESS: base_q   <= cfg_data;
					default:          ;
				endcase
			end
			if (cmd.seq_clear) begin
				offset_acc_q  <= '0;
				next_dim_q    <= '0;
				range_fault_q <= 1'b0;
				fault_dim_q   <= '0;
			end else begin
				if (cmd.check && out_of_range && !range_fault_q) begin
					range_fault_q <= 1'b1;
					fault_dim_q   <= next_dim_q;
				end
				if (cmd.acc_commit) begin
					offset_acc_q <= sum_next;
				end
				if (cmd.dim_advance) begin
					next_dim_q <= next_dim_q + TIDX_W'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		mult_s1 <= PROD_W'(mul_a) * PROD_W'(mul_b);

		// next_dim_q is steady while idle, so the read is ready by the check
		lo_s1 <= lower_mem[next_dim_q];
		hi_s1 <= upper_mem[next_dim_q];

		if (cmd.load_bounds) begin
			lower_mem[ld_idx] <= lower[INDEX_BITS-1:0];
			upper_mem[ld_idx] <= upper[INDEX_BITS-1:0];
			res_kind_q        <= KIND_ACK;
			res_status_q      <= ld_width[IW2-1] ? STAT_WIDTH : STAT_OK;
			res_bad_q         <= DIM_W'(ld_idx);
			res_addr_q        <= '0;
		end
		if (cmd.sub_capture) begin
			sub_s1 <= subscript[INDEX_BITS-1:0];
		end
		if (cmd.check) begin
			width_q <= ADDR_BITS'(width_x);
			sum_q   <= ADDR_BITS'(diff_x);
		end else if (cmd.sum_base) begin
			sum_q <= ADDR_BITS'(base_q);
		end else if (cmd.add_en) begin
			sum_q <= sum_next;
		end
		if (cmd.res_fault) begin
			res_kind_q   <= KIND_ADDR;
			res_status_q <= STAT_RANGE;
			res_bad_q    <= DIM_W'(fault_dim_q);
			res_addr_q   <= '0;
		end
		if (cmd.res_addr) begin
			res_kind_q   <= KIND_ADDR;
			res_status_q <= STAT_OK;
			res_bad_q    <= '0;
			res_addr_q   <= sum_next;
		end
		if (cmd.out_load) begin
			kind_q    <= res_kind_q;
			status_q  <= res_status_q;
			bad_dim_q <= res_bad_q;
			address_q <= FIELD_ADDR_W'(res_addr_q);
		end
	end

	assign kind    = kind_q;
	assign status  = status_q;
	assign bad_dim = bad_dim_q;
	assign address = address_q;

endmodule

FILE: rtl/core/array_descriptor_address_check_core.sv
// ----------------------------------------------------------------------------
// array_descriptor_address_check_core
// Multi-dimensional array address generator with per-dimension bounds checks.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall): op=0 beats load the lower/upper bound
//    of one dimension and return one acknowledge beat (status 2 if the width
//    is negative). op=1 beats carry one subscript each, dimension 0 first;
//    the beat carrying the last of dim_count subscripts returns the element
//    address, or status 1 with the first failing dimension. Other subscript
//    beats return nothing.
//  - Output channel (out_valid/out_stall): one output register; a new beat
//    may be accepted while a finished result waits there.
//  - Schedule: a bounds load passes through the result register to the output
//    register. Each subscript runs the three 32x32 partial products of
//    the Horner step on the single shared multiplier; the closing subscript
//    adds the element-size product and base add (skipped on a fault).
//  - A bounds load in the middle of a subscript sequence abandons it.
//  - Reset clears the sequence, the output valid and the configuration
//    (element size 1, dim_count 1, base_address 0); bound tables are not
//    cleared and must be loaded before use.
//  - While out_stall holds a full output register, the next result waits in
//    the datapath and in_stall stays high until it moves on.
// ----------------------------------------------------------------------------
module array_descriptor_address_check_core
	import adac_pkg::*;
#(
	parameter int MAX_DIMS   = MAX_DIMS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// input beats
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    op,
	input  logic [DIM_W-1:0]        dim,
	input  logic [FIELD_IDX_W-1:0]  lower,
	input  logic [FIELD_IDX_W-1:0]  upper,
	input  logic [FIELD_IDX_W-1:0]  subscript,
	// result beats
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    kind,
	output logic [STATUS_W-1:0]     status,
	output logic [DIM_W-1:0]        bad_dim,
	output logic [FIELD_ADDR_W-1:0] address
);

	adac_cmd_t cmd;
	adac_sts_t sts;

	// sequencer: handshake and multiply schedule
	adac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// tables, check logic, shared multiplier, output register
	adac_datapath #(
		.MAX_DIMS   (MAX_DIMS),
		.INDEX_BITS (INDEX_BITS),
		.ADDR_BITS  (ADDR_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dim       (dim),
		.lower     (lower),
		.upper     (upper),
		.subscript (subscript),
		.kind      (kind),
		.status    (status),
		.bad_dim   (bad_dim),
		.address   (address),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for array_descriptor_address_check_core. Directed beats
// cover bound extremes, zero and negative widths, range faults, abandoned
// sequences and dimension count corner cases. Random traffic then runs under
// several register settings. Every accepted input beat goes through a local
// address predictor. Every result beat is checked field by field against the
// oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;
	import adac_pkg::*;

	localparam int LIMIT_CYCLES    = 600000;
	// output register plus the closing subscript's multiply passes, with margin
	localparam int SETTLE_CYCLES   = 24;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int RANDOM_PHASES   = 5;
	localparam int DIMS            = 8;

	localparam logic [31:0] MIN32    = 32'h8000_0000;
	localparam logic [31:0] MAX32    = 32'h7FFF_FFFF;
	localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;
	localparam longint      IDX_LO   = -(longint'(1) <<< 31);
	localparam longint      IDX_HI   = (longint'(1) <<< 31) - 1;

	typedef struct packed {
		logic                    kind;
		logic [STATUS_W-1:0]     status;
		logic [DIM_W-1:0]        bad_dim;
		logic [FIELD_ADDR_W-1:0] address;
	} addr_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    op;
	logic [DIM_W-1:0]        dim;
	logic [FIELD_IDX_W-1:0]  lower;
	logic [FIELD_IDX_W-1:0]  upper;
	logic [FIELD_IDX_W-1:0]  subscript;
	logic                    out_valid;
	logic                    out_stall;
	logic                    kind;
	logic [STATUS_W-1:0]     status;
	logic [DIM_W-1:0]        bad_dim;
	logic [FIELD_ADDR_W-1:0] address;

	// Predictor copy of the block's state and registers
	logic signed [31:0] lower_bound [DIMS];
	logic signed [31:0] upper_bound [DIMS];
	logic [47:0]        offset_sum;
	logic [2:0]         seq_pos;
	logic               seq_fault;
	logic [2:0]         seq_fault_dim;
	logic [15:0]        elem_bytes;
	logic [3:0]         dims_in_use;
	logic [47:0]        base_addr;
	addr_result_t       expected_q [$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int burst_left     = 0;
	int stall_left     = 0;
	int stall_mode     = 0;

	array_descriptor_address_check_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.dim       (dim),
		.lower     (lower),
		.upper     (upper),
		.subscript (subscript),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.status    (status),
		.bad_dim   (bad_dim),
		.address   (address)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Address predictor
	// ------------------------------------------------------------------------

	// dim_count of 0 behaves as 1, anything above the table depth as the depth
	function automatic int used_dims();
		if (dims_in_use == 0)
			return 1;
		if (dims_in_use > DIMS)
			return DIMS;
		return int'(dims_in_use);
	endfunction

	function automatic void clear_seq();
		offset_sum    = '0;
		seq_pos       = '0;
		seq_fault     = 1'b0;
		seq_fault_dim = '0;
	endfunction

	function automatic void predict_beat(input logic o, input logic [2:0] d,
			input logic signed [31:0] lo, input logic signed [31:0] hi,
			input logic signed [31:0] sub);
		longint       span;
		longint       l;
		longint       h;
		longint       s;
		logic [63:0]  prod;
		addr_result_t r;
		if (o == OP_LOAD) begin
			// bounds are kept even when the width comes out negative
			lower_bound[d] = lo;
			upper_bound[d] = hi;
			clear_seq();
			span = longint'(hi) - longint'(lo) + 1;
			r.kind    = KIND_ACK;
			r.status  = (span < 0) ? STAT_WIDTH : STAT_OK;
			r.bad_dim = d;
			r.address = '0;
			expected_q.push_back(r);
		end else begin
			l    = longint'(lower_bound[seq_pos]);
			h    = longint'(upper_bound[seq_pos]);
			s    = longint'(sub);
			span = h - l + 1;
			// only the first failing dimension is reported
			if ((s < l || s > h) && !seq_fault) begin
				seq_fault     = 1'b1;
				seq_fault_dim = seq_pos;
			end
			// Horner step, wrapping at the address width
			prod       = {16'd0, offset_sum} * 64'(span) + 64'(s - l);
			offset_sum = prod[47:0];
			if (int'(seq_pos) + 1 < used_dims()) begin
				seq_pos = seq_pos + 1'b1;
			end else begin
				r.kind = KIND_ADDR;
				if (seq_fault) begin
					r.status  = STAT_RANGE;
					r.bad_dim = seq_fault_dim;
					r.address = '0;
				end else begin
					prod      = {16'd0, offset_sum} * {48'd0, elem_bytes};
					r.status  = STAT_OK;
					r.bad_dim = '0;
					r.address = base_addr + prod[47:0];
				end
				expected_q.push_back(r);
				clear_seq();
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// One input beat. Bursts of random length with random gaps between them;
	// valid stays up across back-to-back beats of a burst.
	task automatic send_beat(input logic o, input logic [2:0] d, input logic [31:0] lo,
			input logic [31:0] hi, input logic [31:0] sub);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid  = 1'b1;
		op        = o;
		dim       = d;
		lower     = lo;
		upper     = hi;
		subscript = sub;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_beat(o, d, lo, hi, sub);
	endtask

	// unused fields carry noise so that every bit toggles
	task automatic load_bounds(input logic [2:0] d, input logic [31:0] lo,
			input logic [31:0] hi);
		send_beat(OP_LOAD, d, lo, hi, $urandom);
	endtask

	task automatic send_sub(input logic [31:0] sub);
		send_beat(OP_SUB, 3'($urandom_range(0, 7)), $urandom, $urandom, sub);
	endtask

	// Lower valid, wait for every predicted result, then let the block settle
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes only ever happen with the block quiet
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
		drain_results();
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			REG_ELEM_BYTES:   elem_bytes  = value[15:0];
			REG_DIM_COUNT:    dims_in_use = value[3:0];
			REG_BASE_ADDRESS: base_addr   = value;
			default: ;
		endcase
	endtask

	// Random bounds: mostly narrow ranges, some random, zero and negative
	task automatic load_random_bounds(input logic [2:0] d);
		longint l;
		longint h;
		int     m;
		m = $urandom_range(0, 5);
		if (m == 3)
			l = longint'(int'($urandom_range(0, 200)) - 100);
		else
			l = longint'(int'($urandom));
		case (m)
			0: h = longint'(int'($urandom));
			1: begin
				if (l < IDX_LO + 100)
					l = l + 1000;
				h = l - longint'($urandom_range(2, 50));
			end
			2: begin
				if (l == IDX_LO)
					l = l + 1;
				h = l - 1;
			end
			default: begin
				h = l + longint'($urandom_range(0, 15));
				if (h > IDX_HI) begin
					l = l - 16;
					h = h - 16;
				end
			end
		endcase
		load_bounds(d, l[31:0], h[31:0]);
	endtask

	// Next subscript for the predictor's current dimension: mostly in range
	function automatic logic [31:0] pick_subscript();
		longint l;
		longint h;
		longint span;
		longint s;
		int     r;
		l    = longint'(lower_bound[seq_pos]);
		h    = longint'(upper_bound[seq_pos]);
		span = h - l + 1;
		r    = $urandom_range(0, 19);
		if (r == 0 && l > IDX_LO) begin
			s = l - longint'($urandom_range(1, 1000));
			if (s < IDX_LO)
				s = IDX_LO;
		end else if (r == 1 && h < IDX_HI) begin
			s = h + longint'($urandom_range(1, 1000));
			if (s > IDX_HI)
				s = IDX_HI;
		end else if (r == 2 || span <= 0) begin
			return $urandom;
		end else begin
			s = l + longint'(64'({$urandom, $urandom}) % 64'(span));
		end
		return s[31:0];
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset registers: one dimension, one-byte elements, base zero
	task automatic test_reset_values();
		load_bounds(3'd0, -5, 10);
		send_sub(-6);   // just below the lower bound
		send_sub(10);   // upper bound itself
	endtask

	// Full-range, inverted, zero-width and single-element dimensions
	task automatic test_bound_extremes();
		load_bounds(3'd1, MAX32, MIN32);
		load_bounds(3'd2, 100, 99);
		load_bounds(3'd3, MIN32, MAX32);
		load_bounds(3'd4, 7, 7);
		load_bounds(3'd5, MIN32, MIN32 + 3);
		load_bounds(3'd6, MAX32 - 2, MAX32);
		load_bounds(3'd7, -1, 1);
	endtask

	// Negative-width dim 1 fails for any subscript and is reported ahead of
	// the zero-width dim 2, which fails as well
	task automatic test_range_faults();
		write_reg(REG_DIM_COUNT, 48'd3);
		send_sub(3);
		send_sub(0);
		send_sub(99);
	endtask

	// All eight dimensions, largest element size, base at the top so the
	// address wraps
	task automatic test_full_depth();
		write_reg(REG_ELEM_BYTES, 48'd65535);
		write_reg(REG_DIM_COUNT, 48'd8);
		write_reg(REG_BASE_ADDRESS, ADDR_MAX);
		load_bounds(3'd1, -3, 3);
		load_bounds(3'd2, 0, 4);
		send_sub(10);
		send_sub(-3);
		send_sub(4);
		send_sub(MIN32);
		send_sub(7);
		send_sub(MIN32 + 3);
		send_sub(MAX32 - 2);
		send_sub(1);
	endtask

	// A bounds load halfway through a sequence drops the partial offset
	task automatic test_abandoned_sequence();
		send_sub(11);
		send_sub(-3);
		load_bounds(3'd4, 7, 7);
	endtask

	// dim_count 0 acts as a single dimension
	task automatic test_zero_count();
		write_reg(REG_DIM_COUNT, 48'd0);
		send_sub(-5);
	endtask

	// Count lowered below the position reached: next subscript closes it
	task automatic test_count_lowered();
		write_reg(REG_DIM_COUNT, 48'd4);
		send_sub(0);
		send_sub(1);
		write_reg(REG_DIM_COUNT, 48'd2);
		send_sub(2);
	endtask

	task automatic test_random_traffic();
		int phase;
		int sent;
		int action;
		int k;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_ELEM_BYTES, 48'd1);
					write_reg(REG_DIM_COUNT, 48'd1);
					write_reg(REG_BASE_ADDRESS, 48'd0);
				end
				1: begin
					write_reg(REG_ELEM_BYTES, 48'd65535);
					write_reg(REG_DIM_COUNT, 48'd8);
					write_reg(REG_BASE_ADDRESS, ADDR_MAX);
				end
				2: begin
					// above the table depth, behaves as eight
					write_reg(REG_ELEM_BYTES, 48'($urandom_range(1, 65535)));
					write_reg(REG_DIM_COUNT, 48'd15);
					write_reg(REG_BASE_ADDRESS, 48'({$urandom, $urandom}));
				end
				3: begin
					write_reg(REG_ELEM_BYTES, 48'($urandom_range(1, 64)));
					write_reg(REG_DIM_COUNT, 48'd3);
					write_reg(REG_BASE_ADDRESS, 48'({$urandom, $urandom}));
				end
				default: begin
					write_reg(REG_ELEM_BYTES, 48'($urandom_range(1, 65535)));
					write_reg(REG_DIM_COUNT, 48'($urandom_range(0, 15)));
					write_reg(REG_BASE_ADDRESS, 48'({$urandom, $urandom}));
				end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				action = $urandom_range(0, 99);
				if (action < 10) begin
					// noise: any op, any content
					send_beat(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
						$urandom, $urandom, $urandom);
					sent++;
				end else if (action < 25) begin
					load_random_bounds(3'($urandom_range(0, 7)));
					sent++;
				end else if (action < 35 && used_dims() > 1) begin
					// broken sequence cut short by a bounds load
					k = $urandom_range(1, used_dims() - 1);
					repeat (k)
						send_sub(pick_subscript());
					load_random_bounds(3'($urandom_range(0, 7)));
					sent += k + 1;
				end else begin
					// well-formed: subscripts until the sequence closes
					do begin
						send_sub(pick_subscript());
						sent++;
					end while (seq_pos != 0);
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Result channel: stall pattern and checking
	// ------------------------------------------------------------------------

	// Stretches of no stall, random stall, light stall and solid stall
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 48);
		end
		stall_left--;
		case (stall_mode)
			0:       out_stall = 1'b0;
			1:       out_stall = 1'($urandom_range(0, 1));
			2:       out_stall = ($urandom_range(0, 5) == 0);
			default: out_stall = 1'b1;
		endcase
	end

	always @(posedge clk) begin
		addr_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result beat with none expected: kind %0d status %0d bad_dim %0d",
					kind, status, bad_dim);
				mismatch_count++;
			end else begin
				want = expected_q.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					mismatch_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatch_count++;
				end
				if (bad_dim !== want.bad_dim) begin
					$error("bad_dim: expected %0d, got %0d", want.bad_dim, bad_dim);
					mismatch_count++;
				end
				if (address !== want.address) begin
					$error("address: expected %h, got %h", want.address, address);
					mismatch_count++;
				end
			end
		end
	end

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence of tests
	// ------------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		op        = OP_LOAD;
		dim       = '0;
		lower     = '0;
		upper     = '0;
		subscript = '0;

		// predictor matches the block's reset values
		elem_bytes  = 16'd1;
		dims_in_use = 4'd1;
		base_addr   = '0;
		for (int i = 0; i < DIMS; i++) begin
			lower_bound[i] = '0;
			upper_bound[i] = '0;
		end
		clear_seq();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_bound_extremes();
		test_range_faults();
		test_full_depth();
		test_abandoned_sequence();
		test_zero_count();
		test_count_lowered();
		test_random_traffic();

		drain_results();
		if (mismatch_count == 0 && expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
